FILE: rtl/core/dpmq_pkg.sv
`timescale 1ns / 1ps
package dpmq_pkg;
   localparam int QueueDepth = 16;
   localparam int IdxW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      REQ_SCHEDULE = 2'd0,
      REQ_GREETING = 2'd1,
      REQ_TAKE     = 2'd2,
      REQ_PURGE    = 2'd3
   } req_kind_type;

   localparam logic [2:0] CSR_WIN_SHORT  = 3'd0;
   localparam logic [2:0] CSR_WIN_NORMAL = 3'd1;
   localparam logic [2:0] CSR_WIN_LONG   = 3'd2;
   localparam logic [2:0] CSR_JOURNAL    = 3'd3;
   localparam logic [2:0] CSR_PAGE       = 3'd4;
   localparam logic [2:0] CSR_WELCOME    = 3'd5;
   localparam logic [2:0] CSR_FIRST_SIT  = 3'd6;
   localparam logic [2:0] CSR_LATE_SIT   = 3'd7;

   // one queue entry
   typedef struct packed {
      logic [31:0] due;
      logic [31:0] window;
      logic        shown;
      logic [1:0]  prio;
      logic [7:0]  code;
      logic [15:0] handle;
   } entry_type;

   // configuration snapshot for the sequencer
   typedef struct packed {
      logic [31:0] win_short;
      logic [31:0] win_normal;
      logic [31:0] win_long;
      logic [7:0]  journal_code;
      logic [7:0]  page_code;
      logic [7:0]  welcome_code;
      logic [7:0]  first_sit_code;
      logic [7:0]  late_sit_code;
   } cfg_type;
endpackage

FILE: rtl/core/dpmq_csr.sv
`timescale 1ns / 1ps
module dpmq_csr
   import dpmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output cfg_type     cfg
);
   cfg_type cfg_ff;

   // register file with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_short      <= 32'd10000;
         cfg_ff.win_normal     <= 32'd60000;
         cfg_ff.win_long       <= 32'd300000;
         cfg_ff.journal_code   <= 8'd0;
         cfg_ff.page_code      <= 8'd1;
         cfg_ff.welcome_code   <= 8'd2;
         cfg_ff.first_sit_code <= 8'd3;
         cfg_ff.late_sit_code  <= 8'd4;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIN_SHORT:  cfg_ff.win_short      <= csr_data;
            CSR_WIN_NORMAL: cfg_ff.win_normal     <= csr_data;
            CSR_WIN_LONG:   cfg_ff.win_long       <= csr_data;
            CSR_JOURNAL:    cfg_ff.journal_code   <= csr_data[7:0];
            CSR_PAGE:       cfg_ff.page_code      <= csr_data[7:0];
            CSR_WELCOME:    cfg_ff.welcome_code   <= csr_data[7:0];
            CSR_FIRST_SIT:  cfg_ff.first_sit_code <= csr_data[7:0];
            default:        cfg_ff.late_sit_code  <= csr_data[7:0];
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

FILE: rtl/core/deadline_priority_message_queue.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  type, now, code, handle, prio, delay, ...
// rsp       out        rsp_valid/rsp_ready  found, code, handle, count
// csr       in         csr_write            index, data
//
// schedule: a priority walk, then a tail shift, then the response
// take: a scan over the held entries, then the response; purge: a compaction pass, then the response
// greeting: a compaction pass over the held entries, then the insert
// reset is synchronous and empties the queue
// a response waits for rsp_ready; the next request is accepted the cycle after it leaves
module deadline_priority_message_queue
   import dpmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_event_code,
   input  logic [15:0] req_message_handle,
   input  logic [1:0]  req_priority_level,
   input  logic [31:0] req_delay_ms,
   input  logic [1:0]  req_relevance_level,
   input  logic        req_journal_active,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_message_found,
   output logic [7:0]  rsp_found_event_code,
   output logic [15:0] rsp_found_handle,
   output logic [4:0]  rsp_queue_count,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_FILTER, ST_FIND, ST_SHIFT, ST_TAKE, ST_RESP
   } state_type;

   cfg_type cfg;
   dpmq_csr u_csr (.clock, .reset, .csr_write, .csr_index, .csr_data, .cfg);

   entry_type      ent_ff [QueueDepth];
   logic [CntW-1:0] cnt_ff, wr_ff;
   logic [IdxW-1:0] idx_ff;
   logic [CntW-1:0] pos_ff;
   state_type      st_ff;
   req_kind_type   kind_ff;
   logic [31:0]    now_ff;
   logic           journal_ff;
   entry_type      new_ff;
   logic           found_ff;
   logic [7:0]     fcode_ff;
   logic [15:0]    fhandle_ff;

   // shared per-entry evaluation unit
   entry_type cur;
   logic [31:0] limit;
   logic expired, greet, journal_ok, not_due, more, keep;
   logic [31:0] win_sel, win_fix;
   assign cur = ent_ff[idx_ff];
   assign limit = cur.due + cur.window;
   assign expired = now_ff > limit;
   assign not_due = now_ff < cur.due;
   assign greet = cur.code == cfg.welcome_code || cur.code == cfg.first_sit_code
                  || cur.code == cfg.late_sit_code;
   assign journal_ok = cur.code == cfg.journal_code || cur.code == cfg.page_code;
   assign more = {1'b0, idx_ff} < cnt_ff;
   assign keep = (kind_ff == REQ_GREETING) ? !greet : (!cur.shown && !expired);
   always_comb begin
      unique case (req_relevance_level)
         2'd1:    win_sel = cfg.win_short;
         2'd2:    win_sel = cfg.win_long;
         default: win_sel = cfg.win_normal;
      endcase
   end
   assign win_fix = (win_sel == 32'd0) ? cfg.win_normal : win_sel;

   assign req_ready = (st_ff == ST_IDLE) && !rsp_valid;

   // sequencer: filter compacts in place, find scans insert point, shift moves tail down
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid <= 1'b0;
         idx_ff <= '0;
         wr_ff <= '0;
         pos_ff <= '0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (st_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               kind_ff <= req_kind_type'(req_type);
               now_ff <= req_now_ms;
               journal_ff <= req_journal_active;
               new_ff.shown <= 1'b0;
               new_ff.code <= req_event_code;
               new_ff.handle <= req_message_handle;
               found_ff <= 1'b0;
               fcode_ff <= '0;
               fhandle_ff <= '0;
               idx_ff <= '0;
               wr_ff <= '0;
               if (req_type == REQ_GREETING) begin
                  new_ff.prio <= 2'd3;
                  new_ff.due <= req_now_ms;
                  new_ff.window <= (cfg.win_long == 32'd0) ? cfg.win_normal : cfg.win_long;
               end else begin
                  new_ff.prio <= req_priority_level;
                  new_ff.due <= req_now_ms + req_delay_ms;
                  new_ff.window <= win_fix;
               end
               unique case (req_kind_type'(req_type))
                  REQ_SCHEDULE: st_ff <= ST_FIND;
                  REQ_TAKE:     st_ff <= ST_TAKE;
                  default:      st_ff <= ST_FILTER;
               endcase
            end
            ST_FILTER: begin
               if (more && keep) begin
                  ent_ff[wr_ff[IdxW-1:0]] <= cur;
                  wr_ff <= wr_ff + 1'b1;
               end
               if (!more || {1'b0, idx_ff} == cnt_ff - 1'b1) begin
                  cnt_ff <= (more && keep) ? wr_ff + 1'b1 : wr_ff;
                  idx_ff <= '0;
                  st_ff <= (kind_ff == REQ_GREETING) ? ST_FIND : ST_RESP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_FIND: begin
               if (more && cur.prio >= new_ff.prio) begin
                  // full queue and the new entry sorts last: it is dropped
                  if (idx_ff == IdxW'(QueueDepth - 1)) st_ff <= ST_RESP;
                  else idx_ff <= idx_ff + 1'b1;
               end else begin
                  pos_ff <= more ? {1'b0, idx_ff} : cnt_ff;
                  // start shifting from the new last slot (the last slot when full, whose entry is dropped)
                  idx_ff <= (cnt_ff == CntW'(QueueDepth))
                            ? IdxW'(QueueDepth - 1) : cnt_ff[IdxW-1:0];
                  if (cnt_ff != CntW'(QueueDepth)) cnt_ff <= cnt_ff + 1'b1;
                  st_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               if ({1'b0, idx_ff} == pos_ff) begin
                  ent_ff[idx_ff] <= new_ff;
                  st_ff <= ST_RESP;
               end else begin
                  ent_ff[idx_ff] <= ent_ff[idx_ff - 1'b1];
                  idx_ff <= idx_ff - 1'b1;
               end
            end
            ST_TAKE: begin
               if (!more || (!cur.shown && !expired && not_due)) st_ff <= ST_RESP;
               else if (cur.shown || expired || (journal_ff && !journal_ok)) begin
                  if ({1'b0, idx_ff} == cnt_ff - 1'b1) st_ff <= ST_RESP;
                  else idx_ff <= idx_ff + 1'b1;
               end else begin
                  ent_ff[idx_ff].shown <= 1'b1;
                  found_ff <= 1'b1;
                  fcode_ff <= cur.code;
                  fhandle_ff <= cur.handle;
                  st_ff <= ST_RESP;
               end
            end
            default: if (!rsp_valid) begin
               rsp_valid <= 1'b1;
               st_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_message_found = found_ff;
   assign rsp_found_event_code = fcode_ff;
   assign rsp_found_handle = fhandle_ff;
   assign rsp_queue_count = 5'(cnt_ff);

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(QueueDepth)) else $error("count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind_ff != REQ_TAKE |-> !rsp_message_found) else $error("bad found");
`endif
endmodule

FILE: tb/sv/tb_deadline_priority_message_queue.sv
`timescale 1ns / 1ps
module tb_deadline_priority_message_queue;
   import dpmq_pkg::*;

   localparam int Depth = QueueDepth;
   localparam int CycleLimit = 1000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [31:0] req_now_ms;
   logic [7:0]  req_event_code;
   logic [15:0] req_message_handle;
   logic [1:0]  req_priority_level;
   logic [31:0] req_delay_ms;
   logic [1:0]  req_relevance_level;
   logic        req_journal_active;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_message_found;
   logic [7:0]  rsp_found_event_code;
   logic [15:0] rsp_found_handle;
   logic [4:0]  rsp_queue_count;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   deadline_priority_message_queue dut (.*);

   // one expected response
   typedef struct packed {
      logic        found;
      logic [7:0]  code;
      logic [15:0] handle;
      logic [4:0]  count;
   } answer_type;

   // shadow of the queue and its registers
   entry_type   shadow_slots [Depth];
   int          shadow_count;
   cfg_type     shadow_cfg;
   answer_type  pending_answers [$];
   int          mismatches;
   int          cycles;
   bit          quiet_phase;
   logic [31:0] clock_ms;

   // clock and cycle limit
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic bit is_stale(entry_type e, logic [31:0] now);
      logic [31:0] lim;
      lim = e.due + e.window;
      return now > lim;
   endfunction

   function automatic bit is_greeting_code(logic [7:0] c);
      return c == shadow_cfg.welcome_code || c == shadow_cfg.first_sit_code ||
             c == shadow_cfg.late_sit_code;
   endfunction

   function automatic void insert_entry(logic [31:0] now, logic [7:0] c, logic [15:0] h,
                                        logic [1:0] p, logic [31:0] dly, logic [31:0] w);
      entry_type e;
      int pos;
      int n;
      pos = 0;
      n = shadow_count;
      if (w == 0) w = shadow_cfg.win_normal;
      e.due = now + dly;
      e.window = w;
      e.shown = 0;
      e.prio = p;
      e.code = c;
      e.handle = h;
      while (pos < n && shadow_slots[pos].prio >= p) pos++;
      if (pos >= Depth) return;
      if (n >= Depth) n = Depth - 1;
      for (int i = n; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
      shadow_slots[pos] = e;
      shadow_count = n + 1;
   endfunction

   // work out the response to one request
   function automatic answer_type predict_response(req_kind_type kind, logic [31:0] now,
         logic [7:0] c, logic [15:0] h, logic [1:0] p, logic [31:0] dly, logic [1:0] rel,
         logic jrn);
      answer_type a;
      int k;
      logic [31:0] w;
      a = '0;
      case (kind)
         REQ_SCHEDULE: begin
            w = (rel == 1) ? shadow_cfg.win_short :
                (rel == 2) ? shadow_cfg.win_long : shadow_cfg.win_normal;
            insert_entry(now, c, h, p, dly, w);
         end
         REQ_GREETING: begin
            k = 0;
            for (int i = 0; i < shadow_count; i++)
               if (!is_greeting_code(shadow_slots[i].code)) begin
                  shadow_slots[k] = shadow_slots[i];
                  k++;
               end
            shadow_count = k;
            insert_entry(now, c, h, 2'd3, 32'd0, shadow_cfg.win_long);
         end
         REQ_TAKE: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_slots[i].shown || is_stale(shadow_slots[i], now)) continue;
               if (now < shadow_slots[i].due) break;
               if (jrn && shadow_slots[i].code != shadow_cfg.journal_code &&
                   shadow_slots[i].code != shadow_cfg.page_code) continue;
               shadow_slots[i].shown = 1;
               a.found = 1;
               a.code = shadow_slots[i].code;
               a.handle = shadow_slots[i].handle;
               break;
            end
         end
         default: begin
            k = 0;
            for (int i = 0; i < shadow_count; i++)
               if (!shadow_slots[i].shown && !is_stale(shadow_slots[i], now)) begin
                  shadow_slots[k] = shadow_slots[i];
                  k++;
               end
            shadow_count = k;
         end
      endcase
      a.count = shadow_count[4:0];
      return a;
   endfunction

   function automatic bit idle_now();
      return !quiet_phase && ($urandom_range(99) < 28);
   endfunction

   // send one request and record what it should return
   task automatic send_request(req_kind_type kind, logic [31:0] now, logic [7:0] c,
         logic [15:0] h, logic [1:0] p, logic [31:0] dly, logic [1:0] rel, logic jrn);
      while (idle_now()) @(posedge clock);
      req_valid <= 1;
      req_type <= kind;
      req_now_ms <= now;
      req_event_code <= c;
      req_message_handle <= h;
      req_priority_level <= p;
      req_delay_ms <= dly;
      req_relevance_level <= rel;
      req_journal_active <= jrn;
      pending_answers.insert(pending_answers.size(),
                             predict_response(kind, now, c, h, p, dly, rel, jrn));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 0;
      // the block is busy after an accept, so this gap costs nothing
      @(posedge clock);
   endtask

   // wait until every response is in, then let the block settle
   task automatic drain();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_WIN_SHORT:  shadow_cfg.win_short = val;
         CSR_WIN_NORMAL: shadow_cfg.win_normal = val;
         CSR_WIN_LONG:   shadow_cfg.win_long = val;
         CSR_JOURNAL:    shadow_cfg.journal_code = val[7:0];
         CSR_PAGE:       shadow_cfg.page_code = val[7:0];
         CSR_WELCOME:    shadow_cfg.welcome_code = val[7:0];
         CSR_FIRST_SIT:  shadow_cfg.first_sit_code = val[7:0];
         default:        shadow_cfg.late_sit_code = val[7:0];
      endcase
      @(posedge clock);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
            end else begin
               want = pending_answers.pop_front();
               if (want.found !== rsp_message_found || want.code !== rsp_found_event_code ||
                   want.handle !== rsp_found_handle || want.count !== rsp_queue_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want.found, want.code, want.handle, want.count, rsp_message_found,
                        rsp_found_event_code, rsp_found_handle, rsp_queue_count);
               end
            end
         end
         rsp_ready <= !idle_now();
      end
   end

   // code that the journal and greeting registers are likely to match
   function automatic logic [7:0] pick_code();
      return ($urandom_range(3) != 0) ? 8'($urandom_range(5)) : 8'($urandom);
   endfunction

   task automatic test_directed();
      // extremes of the fields, schedule and take requests
      send_request(REQ_TAKE, 32'd0, 0, 0, 0, 0, 0, 0);
      send_request(REQ_SCHEDULE, 32'd100, 8'hff, 16'hffff, 2'd3, 32'd0, 2'd3, 1);
      send_request(REQ_SCHEDULE, 32'd100, 8'h00, 16'h0000, 2'd0, 32'd5, 2'd1, 0);
      send_request(REQ_SCHEDULE, 32'hffff_ffff, 8'h01, 16'h1234, 2'd1, 32'hffff_ffff, 2'd2, 0);
      send_request(REQ_TAKE, 32'd100, 0, 0, 0, 0, 0, 1);
      send_request(REQ_TAKE, 32'd104, 0, 0, 0, 0, 0, 0);
      send_request(REQ_TAKE, 32'd105, 0, 0, 0, 0, 0, 1);
      // greeting removes greeting codes
      send_request(REQ_SCHEDULE, 32'd200, 8'd3, 16'h55, 2'd2, 32'd0, 2'd0, 0);
      send_request(REQ_GREETING, 32'd200, 8'd2, 16'haa, 2'd0, 32'd99, 2'd1, 0);
      send_request(REQ_PURGE, 32'd200, 0, 0, 0, 0, 0, 0);
      // expired and wrapped due times
      send_request(REQ_TAKE, 32'hffff_fff0, 0, 0, 0, 0, 0, 0);
      send_request(REQ_PURGE, 32'hffff_ffff, 0, 0, 0, 0, 0, 0);
      // overflow: fill past the depth with mixed priorities
      for (int i = 0; i < 18; i++)
         send_request(REQ_SCHEDULE, 32'd300, 8'(i), 16'(i), 2'(i % 4), 32'd0, 2'd0, 0);
      send_request(REQ_SCHEDULE, 32'd300, 8'd9, 16'd9, 2'd0, 32'd0, 2'd0, 0);
      drain();
   endtask

   task automatic test_random(int n, bit sparse_time);
      logic [31:0] step;
      for (int i = 0; i < n; i++) begin
         step = sparse_time ? $urandom : $urandom_range(3000);
         clock_ms += step;
         send_request(req_kind_type'($urandom_range(3)),
            ($urandom_range(15) == 0) ? $urandom : clock_ms, pick_code(), 16'($urandom),
            2'($urandom), ($urandom_range(7) == 0) ? $urandom : $urandom_range(20000),
            2'($urandom_range(3)), 1'($urandom));
      end
   endtask

   task automatic test_config_sweep();
      write_csr(CSR_WIN_SHORT, 32'd1);
      write_csr(CSR_WIN_NORMAL, 32'hffff_ffff);
      write_csr(CSR_WIN_LONG, 32'd500);
      write_csr(CSR_JOURNAL, 32'd255);
      write_csr(CSR_PAGE, 32'd5);
      write_csr(CSR_WELCOME, 32'd0);
      write_csr(CSR_FIRST_SIT, 32'd1);
      write_csr(CSR_LATE_SIT, 32'd255);
      test_random(500, 0);
      drain();
      // zero windows fall back to the normal window, itself zero
      write_csr(CSR_WIN_SHORT, 32'd0);
      write_csr(CSR_WIN_NORMAL, 32'd0);
      write_csr(CSR_WIN_LONG, 32'hffff_ffff);
      write_csr(CSR_JOURNAL, 32'd2);
      write_csr(CSR_LATE_SIT, 32'd4);
      test_random(500, 1);
      drain();
   endtask

   // stimulus
   initial begin
      mismatches = 0;
      cycles = 0;
      clock_ms = 0;
      quiet_phase = 0;
      reset = 1;
      req_valid = 0;
      req_type = REQ_SCHEDULE;
      req_now_ms = 0;
      req_event_code = 0;
      req_message_handle = 0;
      req_priority_level = 0;
      req_delay_ms = 0;
      req_relevance_level = 0;
      req_journal_active = 0;
      csr_write = 0;
      csr_index = CSR_WIN_SHORT;
      csr_data = 0;
      shadow_count = 0;
      shadow_cfg = '{32'd10000, 32'd60000, 32'd300000, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(500, 0);
      drain();
      quiet_phase = 1;
      test_random(200, 0);
      quiet_phase = 0;
      drain();
      test_config_sweep();
      test_random(300, 0);
      drain();
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/core/dpmq_pkg.sv
rtl/core/dpmq_csr.sv
rtl/core/deadline_priority_message_queue.sv
tb/sv/tb_deadline_priority_message_queue.sv
